// ===== src/ilid_pkg.sv =====
// Shared types and constants for the indexed list insert/delete unit.
`default_nettype none
package ilid_pkg;

    // Widest position the cell row ever sees (capacity up to 1024).
    localparam int MAX_IDX_W = 10;
    localparam int DATA_W    = 32;

    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_FRONT  = 3'd1;
    localparam logic [2:0] CMD_APPEND = 3'd2;
    localparam logic [2:0] CMD_INSERT = 3'd3;
    localparam logic [2:0] CMD_DELETE = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic signed [DATA_W-1:0] ALL_ONES = -32'sd1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE
    } t_ilid_op;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [6:0]               position;
        logic signed [DATA_W-1:0] value_in;
    } t_ilid_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     hit;
        logic [6:0]               count;
        logic [1:0]               status;
    } t_ilid_result;

    // Broadcast to every cell in the row.
    typedef struct packed {
        t_ilid_op                 op;
        logic [MAX_IDX_W-1:0]     pos;
        logic signed [DATA_W-1:0] value;
    } t_ilid_ctl;

endpackage
`default_nettype wire

// ===== src/ilid_cell.sv =====
// One list slot: holds an entry and shifts with its neighbors on insert/delete.
`default_nettype none
module ilid_cell #(
    parameter int IDX = 0
) (
    input  wire                                  i_clk,
    input  wire ilid_pkg::t_ilid_ctl             i_ctl,
    input  wire logic signed [ilid_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [ilid_pkg::DATA_W-1:0] i_right,
    output logic signed [ilid_pkg::DATA_W-1:0]   o_value
);

    localparam logic [ilid_pkg::MAX_IDX_W-1:0] MY_IDX = ilid_pkg::MAX_IDX_W'(IDX);

    logic signed [ilid_pkg::DATA_W-1:0] r_value;
    logic signed [ilid_pkg::DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            ilid_pkg::OP_INSERT: begin
                if (MY_IDX > i_ctl.pos) begin
                    n_value = i_left;
                end else if (MY_IDX == i_ctl.pos) begin
                    n_value = i_ctl.value;
                end
            end
            ilid_pkg::OP_DELETE: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_value = i_right;
                end
            end
            ilid_pkg::OP_NONE: begin
                n_value = r_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // Payload only, no reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

// ===== src/indexed_list_insert_delete_unit.sv =====
// Top level of the indexed list unit: command decode, count and the row of cells.
//
// Usage: drive i_item (cmd, position, value_in) and raise start; a command beat
// is taken at each rising edge with start high and busy low. busy stays low,
// so a new command may be issued every cycle.
// Each command gives exactly one result beat on o_result, marked by o_valid for
// one cycle, in the cycle right after the command was taken (throughput 1
// command per cycle). The receiver cannot stall the result.
// Inserts and deletes move every entry behind the affected position by one
// slot at once: each cell of the CAPACITY-long row loads from its left or right
// neighbor. Reads select the addressed cell through a mux into the result
// register.
// Reset (i_rst_n low, synchronous) empties the list and drops o_valid; cell
// contents are not cleared, since only positions below the count are readable.
// Status reports done, ignored (position out of range or unknown command) or
// full (insert rejected at capacity); count is the entry count after the
// command, reported in 7 bits.
`default_nettype none
module indexed_list_insert_delete_unit #(
    parameter int CAPACITY = 64
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    input  wire ilid_pkg::t_ilid_item i_item,
    output logic                      busy,
    output logic                      o_valid,
    output ilid_pkg::t_ilid_result    o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_valid;
    ilid_pkg::t_ilid_result r_result;
    ilid_pkg::t_ilid_result n_result;
    ilid_pkg::t_ilid_ctl    ctl;

    logic signed [ilid_pkg::DATA_W-1:0] cell_val [CAPACITY];
    logic signed [ilid_pkg::DATA_W-1:0] rd_val;

    logic             accept;
    logic             full;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CAP_CNT);
    assign pos_c  = CMP_W'(i_item.position);
    assign cnt_c  = CMP_W'(r_count);

    // Read select: at most one cell matches, OR the masked values together.
    always_comb begin
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_c == CMP_W'(i)) begin
                rd_val = rd_val | cell_val[i];
            end
        end
    end

    always_comb begin
        n_count            = r_count;
        ctl.op             = ilid_pkg::OP_NONE;
        ctl.pos            = ilid_pkg::MAX_IDX_W'(i_item.position);
        ctl.value          = i_item.value_in;
        n_result.value_out = ilid_pkg::ALL_ONES;
        n_result.hit       = 1'b0;
        n_result.status    = ilid_pkg::ST_DONE;

        unique case (i_item.cmd)
            ilid_pkg::CMD_READ: begin
                if (pos_c < cnt_c) begin
                    n_result.value_out = rd_val;
                    n_result.hit       = 1'b1;
                end else begin
                    n_result.status = ilid_pkg::ST_IGNORED;
                end
            end
            ilid_pkg::CMD_FRONT: begin
                if (full) begin
                    n_result.status = ilid_pkg::ST_FULL;
                end else begin
                    ctl.op  = ilid_pkg::OP_INSERT;
                    ctl.pos = '0;
                    n_count = r_count + CNT_ONE;
                end
            end
            ilid_pkg::CMD_APPEND: begin
                if (full) begin
                    n_result.status = ilid_pkg::ST_FULL;
                end else begin
                    ctl.op  = ilid_pkg::OP_INSERT;
                    ctl.pos = ilid_pkg::MAX_IDX_W'(r_count);
                    n_count = r_count + CNT_ONE;
                end
            end
            ilid_pkg::CMD_INSERT: begin
                // position check ranks above the full check
                if (pos_c > cnt_c) begin
                    n_result.status = ilid_pkg::ST_IGNORED;
                end else if (full) begin
                    n_result.status = ilid_pkg::ST_FULL;
                end else begin
                    ctl.op  = ilid_pkg::OP_INSERT;
                    n_count = r_count + CNT_ONE;
                end
            end
            ilid_pkg::CMD_DELETE: begin
                if (pos_c >= cnt_c) begin
                    n_result.status = ilid_pkg::ST_IGNORED;
                end else begin
                    ctl.op  = ilid_pkg::OP_DELETE;
                    n_count = r_count - CNT_ONE;
                end
            end
            default: begin
                n_result.status = ilid_pkg::ST_IGNORED;
            end
        endcase

        if (!accept) begin
            ctl.op  = ilid_pkg::OP_NONE;
            n_count = r_count;
        end
        n_result.count = 7'(n_count);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ilid_pkg::DATA_W-1:0] left_val;
        logic signed [ilid_pkg::DATA_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = ctl.value;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        ilid_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== src/ilid_checker.sv =====
// Port-level assertions for the indexed list unit, bound to the top level.
`default_nettype none
module ilid_checker #(
    parameter int CAPACITY = 64
) (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         start,
    input wire                         busy,
    input wire                         o_valid,
    input wire ilid_pkg::t_ilid_result o_result
);

    // one result beat per command beat, in the cycle after it
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == ($past(i_rst_n) && $past(start && !busy)))
        else $error("result beat does not match command beat");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.hit) |-> (o_result.status == ilid_pkg::ST_DONE))
        else $error("hit with non-done status");

    a_miss_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.hit) |-> (o_result.value_out == ilid_pkg::ALL_ONES))
        else $error("miss without all-ones value");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ilid_pkg::ST_FULL)
            |-> (o_result.count == 7'(CAPACITY)))
        else $error("full status below capacity");

endmodule

bind indexed_list_insert_delete_unit ilid_checker #(.CAPACITY(CAPACITY)) u_ilid_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the indexed list insert/delete unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP = 64;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   start    = 1'b0;
    ilid_pkg::t_ilid_item   cmd_item = '0;
    logic                   busy;
    logic                   o_valid;
    ilid_pkg::t_ilid_result o_result;

    indexed_list_insert_delete_unit #(
        .CAPACITY(LIST_CAP)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (cmd_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #4 i_clk = ~i_clk;

    class list_scoreboard;
        logic signed [31:0]     shadow_list[$];
        ilid_pkg::t_ilid_result pending_results[$];
        int                     errors    = 0;
        int                     n_cmds    = 0;
        int                     n_results = 0;
        int                     n_hits    = 0;
        int                     n_full    = 0;
        int                     n_ignored = 0;
        int                     peak      = 0;

        function int size();
            return shadow_list.size();
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Apply one accepted command to the shadow list and queue its result.
        function void note_cmd(ilid_pkg::t_ilid_item it);
            ilid_pkg::t_ilid_result r;
            int                     n;
            int                     p;
            logic                   full;
            n           = shadow_list.size();
            p           = it.position;
            full        = (n >= LIST_CAP);
            r.value_out = ilid_pkg::ALL_ONES;
            r.hit       = 1'b0;
            r.status    = ilid_pkg::ST_DONE;
            case (it.cmd)
                ilid_pkg::CMD_READ: begin
                    if (p < n) begin
                        r.value_out = shadow_list[p];
                        r.hit       = 1'b1;
                    end else begin
                        r.status = ilid_pkg::ST_IGNORED;
                    end
                end
                ilid_pkg::CMD_FRONT: begin
                    if (full) r.status = ilid_pkg::ST_FULL;
                    else shadow_list.push_front(it.value_in);
                end
                ilid_pkg::CMD_APPEND: begin
                    if (full) r.status = ilid_pkg::ST_FULL;
                    else shadow_list.push_back(it.value_in);
                end
                ilid_pkg::CMD_INSERT: begin
                    // position check wins over the full check
                    if (p > n) r.status = ilid_pkg::ST_IGNORED;
                    else if (full) r.status = ilid_pkg::ST_FULL;
                    else shadow_list.insert(p, it.value_in);
                end
                ilid_pkg::CMD_DELETE: begin
                    if (p >= n) r.status = ilid_pkg::ST_IGNORED;
                    else shadow_list.delete(p);
                end
                default: r.status = ilid_pkg::ST_IGNORED;
            endcase
            r.count = 7'(shadow_list.size());
            if (shadow_list.size() > peak) peak = shadow_list.size();
            pending_results.push_back(r);
            n_cmds++;
        endfunction

        function void check_result(ilid_pkg::t_ilid_result got);
            ilid_pkg::t_ilid_result exp;
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            n_results++;
            if (exp.hit) n_hits++;
            if (exp.status == ilid_pkg::ST_FULL) n_full++;
            if (exp.status == ilid_pkg::ST_IGNORED) n_ignored++;
            if (got.value_out !== exp.value_out) begin
                $error("value_out: expected %0d, got %0d", exp.value_out, got.value_out);
                errors++;
            end
            if (got.hit !== exp.hit) begin
                $error("hit: expected %0d, got %0d", exp.hit, got.hit);
                errors++;
            end
            if (got.count !== exp.count) begin
                $error("count: expected %0d, got %0d", exp.count, got.count);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    list_scoreboard sb = new();
    logic           filling = 1'b1;

    // Sample mid-cycle: values seen here are the ones the next rising edge takes.
    always @(negedge i_clk) begin
        if (o_valid === 1'b1) sb.check_result(o_result);
        if (i_rst_n && start && !busy) sb.note_cmd(cmd_item);
    end

    // Called at a rising edge; returns at the edge that takes the beat.
    task automatic issue_cmd(logic [2:0] cmd, logic [6:0] pos, logic signed [31:0] val);
        ilid_pkg::t_ilid_item it;
        it.cmd      = cmd;
        it.position = pos;
        it.value_in = val;
        start    <= 1'b1;
        cmd_item <= it;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic pause_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return ilid_pkg::ALL_ONES;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed commands that fill the list to capacity and drain it
    // again, with some out-of-range positions and unknown opcodes mixed in.
    function automatic ilid_pkg::t_ilid_item pick_cmd();
        ilid_pkg::t_ilid_item it;
        int                   n;
        int                   roll;
        n           = sb.size();
        roll        = $urandom_range(0, 99);
        it.value_in = pick_value();
        it.position = (n == 0) ? 7'd0 : 7'($urandom_range(0, n - 1));
        if (roll < 6) begin
            it.cmd      = 3'($urandom_range(0, 7));
            it.position = 7'($urandom_range(0, 127));
        end else if (roll < 20) begin
            it.cmd = ilid_pkg::CMD_READ;
        end else if (filling ? roll < 85 : roll < 32) begin
            case ($urandom_range(0, 2))
                0:       it.cmd = ilid_pkg::CMD_FRONT;
                1:       it.cmd = ilid_pkg::CMD_APPEND;
                default: begin
                    it.cmd      = ilid_pkg::CMD_INSERT;
                    it.position = 7'($urandom_range(0, n));
                end
            endcase
        end else begin
            it.cmd = ilid_pkg::CMD_DELETE;
        end
        return it;
    endfunction

    // Each cycle is left idle with probability idle_pct percent.
    task automatic run_random(int n_items, int idle_pct);
        ilid_pkg::t_ilid_item it;
        for (int k = 0; k < n_items; k++) begin
            while ($urandom_range(0, 99) < idle_pct) pause_cycles(1);
            it = pick_cmd();
            issue_cmd(it.cmd, it.position, it.value_in);
            if (sb.size() == LIST_CAP && $urandom_range(0, 5) == 0) filling = 1'b0;
            if (sb.size() == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
        end
    endtask

    initial begin
        int w;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list misses, inserts at front, middle and end, extremes, bad opcodes
        issue_cmd(ilid_pkg::CMD_READ,   7'd0,   32'sd7);
        issue_cmd(ilid_pkg::CMD_DELETE, 7'd0,   32'sd7);
        issue_cmd(ilid_pkg::CMD_INSERT, 7'd1,   32'sd9);
        issue_cmd(ilid_pkg::CMD_INSERT, 7'd0,   32'sd5);
        issue_cmd(ilid_pkg::CMD_FRONT,  7'd127, 32'sh8000_0000);
        issue_cmd(ilid_pkg::CMD_APPEND, 7'd127, 32'sh7fff_ffff);
        issue_cmd(ilid_pkg::CMD_INSERT, 7'd3,   ilid_pkg::ALL_ONES);
        issue_cmd(ilid_pkg::CMD_INSERT, 7'd1,   32'sd0);
        issue_cmd(ilid_pkg::CMD_READ,   7'd0,   32'sd0);
        issue_cmd(ilid_pkg::CMD_READ,   7'd4,   32'sd0);
        issue_cmd(ilid_pkg::CMD_READ,   7'd5,   32'sd0);
        issue_cmd(ilid_pkg::CMD_READ,   7'd127, ilid_pkg::ALL_ONES);
        issue_cmd(3'd5,                 7'd127, ilid_pkg::ALL_ONES);
        issue_cmd(3'd6,                 7'd0,   32'sd1);
        issue_cmd(3'd7,                 7'd64,  32'sh5555_aaaa);
        issue_cmd(ilid_pkg::CMD_DELETE, 7'd127, 32'sd0);
        issue_cmd(ilid_pkg::CMD_INSERT, 7'd127, 32'sd3);
        issue_cmd(ilid_pkg::CMD_DELETE, 7'd4,   32'sd0);
        issue_cmd(ilid_pkg::CMD_DELETE, 7'd0,   32'sd0);
        issue_cmd(ilid_pkg::CMD_DELETE, 7'd1,   32'sd0);
        issue_cmd(ilid_pkg::CMD_READ,   7'd0,   32'sd0);
        issue_cmd(ilid_pkg::CMD_READ,   7'd1,   32'sd0);

        run_random(270, 23);
        run_random(270, 49);
        run_random(270, 0);
        start <= 1'b0;

        w = 0;
        while (sb.outstanding() > 0 && w < 100) begin
            @(posedge i_clk);
            w++;
        end
        repeat (4) @(posedge i_clk);

        if (sb.outstanding() > 0) $error("%0d results never arrived", sb.outstanding());
        $display("%0d commands sent, %0d results checked, list peaked at %0d entries",
                 sb.n_cmds, sb.n_results, sb.peak);
        $display("%0d read hits, %0d rejected as full, %0d ignored",
                 sb.n_hits, sb.n_full, sb.n_ignored);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ilid_pkg.sv
src/ilid_cell.sv
src/indexed_list_insert_delete_unit.sv
src/ilid_checker.sv
tb/tb_top.sv
